// ===== hw/rtl/deadline_sorted_event_queue_unit_defines.svh =====
// Assertion macros shared by the event queue RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DEADLINE_SORTED_EVENT_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_SORTED_EVENT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DSEQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define DSEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dseq_pkg.sv =====
// Shared types, codes and defaults for the deadline sorted event queue.
// Used by dseq_cell and deadline_sorted_event_queue_unit; no dependencies.
package dseq_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int JOB_BITS_DEFAULT  = 16;

   // fixed field widths on the ports
   localparam int OPCODE_W = 2;
   localparam int JOB_W    = 16;
   localparam int WHEN_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT_ABS = 2'd0,
      OP_INSERT_REL = 2'd1,
      OP_TICK       = 2'd2,
      OP_POP        = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic pop_en;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/deadline_sorted_event_queue_unit.sv =====
// Deadline sorted event queue: keeps up to DEPTH events (job id, due time in ms) sorted by
// due time in a row of cells, earliest at the head, equal times in arrival order, plus a
// millisecond clock. Opcodes insert at an absolute time, insert relative to the clock, tick
// the clock, or pop the head once the clock is strictly past its due time (wrapping signed
// compare). One item is taken per cycle and each item yields one result in the next cycle:
// every cell compares the new due time in parallel and the insert position resolves along
// the cell chain within that cycle. The result register frees itself as it is taken, so the
// block keeps accepting while a result is waiting, unless the result side stalls.
// Depends on dseq_pkg, dseq_cell and deadline_sorted_event_queue_unit_defines.svh.
`include "deadline_sorted_event_queue_unit_defines.svh"

module deadline_sorted_event_queue_unit
   import dseq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT,
   parameter int JOB_BITS  = JOB_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // job_id[15:0], when_ms[47:16]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // popped_job[15:0], entry_count[20:16], zero[23:21]
   output logic [2:0]  rsp_tuser    // status[1:0], popped_valid[2]
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // input fields
   opcode_type            opcode;
   logic [JOB_W-1:0]      job_id;
   logic [WHEN_W-1:0]     when_ms;
   logic [63:0]           when_wide;
   logic [31:0]           job_wide;
   logic [TIME_BITS-1:0]  when_t;
   logic [JOB_BITS-1:0]   job_t;

   // cell row
   cell_ctrl_type         ctrl;
   logic [TIME_BITS-1:0]  new_due;
   logic [DEPTH-1:0]      valid_vec;
   logic [TIME_BITS-1:0]  due_vec [DEPTH];
   logic [JOB_BITS-1:0]   job_vec [DEPTH];
   logic [DEPTH:0]        prior_chain;

   // control
   logic                  req_fire;
   logic                  full;
   logic                  can_pop;
   logic [TIME_BITS-1:0]  head_diff;
   logic [31:0]           head_job_wide;
   status_type            status;
   logic                  pop_ok;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [31:0]           count_wide;

   // result register
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [JOB_W-1:0]      rsp_job_ff;
   logic                  rsp_pvalid_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign opcode    = opcode_type'(req_tuser);
   assign job_id    = req_tdata[15:0];
   assign when_ms   = req_tdata[47:16];
   assign when_wide = {32'd0, when_ms};
   assign job_wide  = {16'd0, job_id};
   assign when_t    = when_wide[TIME_BITS-1:0];
   assign job_t     = job_wide[JOB_BITS-1:0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // head check and fill state
   assign full      = valid_vec[DEPTH-1];
   assign head_diff = due_vec[0] - now_ff;
   assign can_pop   = valid_vec[0] && head_diff[TIME_BITS-1];

   // decode the item into a cell command and a status
   always_comb begin
      ctrl.insert_en = 1'b0;
      ctrl.pop_en    = 1'b0;
      new_due        = when_t;
      status         = ST_DONE;
      pop_ok         = 1'b0;
      now_in         = now_ff;
      count_in       = count_ff;
      case (opcode)
         OP_INSERT_ABS, OP_INSERT_REL: begin
            if (opcode == OP_INSERT_REL) begin
               new_due = now_ff + when_t;
            end
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert_en = req_fire;
               if (req_fire) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (req_fire) begin
               now_in = now_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (can_pop) begin
               pop_ok       = 1'b1;
               ctrl.pop_en  = req_fire;
               if (req_fire) begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               status = ST_NONE;
            end
         end
         default: begin
            status = ST_NONE;
         end
      endcase
   end

   // row of slot cells, head at index 0
   assign prior_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 left_valid;
      logic [TIME_BITS-1:0] left_due;
      logic [JOB_BITS-1:0]  left_job;
      logic                 right_valid;
      logic [TIME_BITS-1:0] right_due;
      logic [JOB_BITS-1:0]  right_job;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
         assign left_due   = new_due;
         assign left_job   = job_t;
      end else begin : g_mid
         assign left_valid = valid_vec[i-1];
         assign left_due   = due_vec[i-1];
         assign left_job   = job_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_due   = due_vec[i];
         assign right_job   = job_vec[i];
      end else begin : g_body
         assign right_valid = valid_vec[i+1];
         assign right_due   = due_vec[i+1];
         assign right_job   = job_vec[i+1];
      end

      dseq_cell #(
         .TIME_BITS (TIME_BITS),
         .JOB_BITS  (JOB_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_due     (new_due),
         .new_job     (job_t),
         .left_valid  (left_valid),
         .left_due    (left_due),
         .left_job    (left_job),
         .prior_in    (prior_chain[i]),
         .right_valid (right_valid),
         .right_due   (right_due),
         .right_job   (right_job),
         .prior_out   (prior_chain[i+1]),
         .valid       (valid_vec[i]),
         .due         (due_vec[i]),
         .job         (job_vec[i])
      );
   end

   // clock and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         count_ff <= '0;
      end else begin
         now_ff   <= now_in;
         count_ff <= count_in;
      end
   end

   assign head_job_wide = 32'(job_vec[0]);
   assign count_wide    = 32'(count_in);

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status;
         rsp_pvalid_ff <= pop_ok;
         rsp_job_ff    <= pop_ok ? head_job_wide[JOB_W-1:0] : '0;
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_count_ff, rsp_job_ff};
   assign rsp_tuser  = {rsp_pvalid_ff, rsp_status_ff};

   // checks
   `DSEQ_ASSERT_SAME(a_count_matches_cells, clock, reset, 1'b1,
      $countones(valid_vec) == int'(count_ff), "fill count differs from valid cells")
   `DSEQ_ASSERT_NEXT(a_pop_shrinks, clock, reset, req_fire && ctrl.pop_en,
      count_ff == $past(count_ff) - 1'b1, "successful pop did not remove one event")
   `DSEQ_ASSERT_NEXT(a_full_drop_keeps, clock, reset,
      req_fire && full && (opcode == OP_INSERT_ABS || opcode == OP_INSERT_REL),
      count_ff == $past(count_ff) && valid_vec == $past(valid_vec),
      "dropped insert changed the queue")
   `DSEQ_ASSERT_SAME(a_pop_status, clock, reset, rsp_valid_ff && rsp_pvalid_ff,
      rsp_status_ff == ST_DONE, "popped result without done status")

endmodule

// ===== hw/rtl/dseq_cell.sv =====
// One slot of the sorted event chain: holds a due time and a job id.
// Depends on dseq_pkg; instantiated in a row by the queue top level.
module dseq_cell
   import dseq_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT,
   parameter int JOB_BITS  = JOB_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [TIME_BITS-1:0] new_due,
   input  logic [JOB_BITS-1:0]  new_job,
   // neighbor toward the head
   input  logic                 left_valid,
   input  logic [TIME_BITS-1:0] left_due,
   input  logic [JOB_BITS-1:0]  left_job,
   input  logic                 prior_in,
   // neighbor toward the tail
   input  logic                 right_valid,
   input  logic [TIME_BITS-1:0] right_due,
   input  logic [JOB_BITS-1:0]  right_job,
   output logic                 prior_out,
   output logic                 valid,
   output logic [TIME_BITS-1:0] due,
   output logic [JOB_BITS-1:0]  job
);

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [JOB_BITS-1:0]  job_ff, job_in;
   logic [TIME_BITS-1:0] diff;
   logic                 ins_here;

   // new event goes strictly before this slot (wrapping compare)
   assign diff      = new_due - due_ff;
   assign ins_here  = valid_ff && diff[TIME_BITS-1];
   assign prior_out = prior_in || ins_here;

   // slot update: shift toward tail, take the new event, or shift toward head
   always_comb begin
      valid_in = valid_ff;
      due_in   = due_ff;
      job_in   = job_ff;
      if (ctrl.insert_en) begin
         if (prior_in) begin
            valid_in = left_valid;
            due_in   = left_due;
            job_in   = left_job;
         end else if (ins_here || (!valid_ff && left_valid)) begin
            valid_in = 1'b1;
            due_in   = new_due;
            job_in   = new_job;
         end
      end else if (ctrl.pop_en) begin
         valid_in = right_valid;
         due_in   = right_due;
         job_in   = right_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset, gated by valid everywhere
   always_ff @(posedge clock) begin
      due_ff <= due_in;
      job_ff <= job_in;
   end

   assign valid = valid_ff;
   assign due   = due_ff;
   assign job   = job_ff;

endmodule
